// ----- rtl/udls_pkg.sv -----
// ----------------------------------------------------------------------------
// udls_pkg
// Types and character constants shared by the diff line scanner files.
// ----------------------------------------------------------------------------
package udls_pkg;

  localparam int OUT_NUM_W = 31;

  typedef enum logic [2:0] {
    KIND_FILE_HEADER = 3'd0,
    KIND_HUNK_HEADER = 3'd1,
    KIND_CONTEXT     = 3'd2,
    KIND_ADDED       = 3'd3,
    KIND_REMOVED     = 3'd4,
    KIND_NO_NEWLINE  = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    CLS_EMPTY  = 3'd0,
    CLS_SPACE  = 3'd1,
    CLS_PLUS   = 3'd2,
    CLS_MINUS  = 3'd3,
    CLS_BSLASH = 3'd4,
    CLS_AT     = 3'd5,
    CLS_OTHER  = 3'd6
  } cls_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef struct packed {
    logic step;
    logic clear;
  } numf_ctl_t;

  localparam logic [15:0] CH_LF     = 16'h000A;
  localparam logic [15:0] CH_CR     = 16'h000D;
  localparam logic [15:0] CH_PS     = 16'h2029;
  localparam logic [15:0] CH_NC0    = 16'hFDD0;
  localparam logic [15:0] CH_NC1    = 16'hFDD1;
  localparam logic [15:0] CH_SPACE  = 16'h0020;
  localparam logic [15:0] CH_PLUS   = 16'h002B;
  localparam logic [15:0] CH_MINUS  = 16'h002D;
  localparam logic [15:0] CH_BSLASH = 16'h005C;
  localparam logic [15:0] CH_AT     = 16'h0040;
  localparam logic [15:0] CH_ZERO   = 16'h0030;
  localparam logic [15:0] CH_NINE   = 16'h0039;

endpackage

// ----- rtl/udls_in_if.sv -----
// ----------------------------------------------------------------------------
// udls_in_if
// Text channel: one code unit or an end-of-text command per item.
// ----------------------------------------------------------------------------
interface udls_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] char_code;

  modport source (output valid, command, char_code, input ready);
  modport sink   (input valid, command, char_code, output ready);
endinterface

// ----- rtl/udls_out_if.sv -----
// ----------------------------------------------------------------------------
// udls_out_if
// Line channel: one classified display line per item.
// ----------------------------------------------------------------------------
interface udls_out_if;
  import udls_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [2:0]           line_kind;
  logic [OUT_NUM_W-1:0] old_number;
  logic [OUT_NUM_W-1:0] new_number;
  logic                 is_continuation;

  modport source (output valid, line_kind, old_number, new_number, is_continuation,
                  input ready);
  modport sink   (input valid, line_kind, old_number, new_number, is_continuation,
                  output ready);
endinterface

// ----- rtl/unified_diff_line_scanner_top.sv -----
// ----------------------------------------------------------------------------
// unified_diff_line_scanner_top
// Classifies the lines of unified diff text streamed one code unit at a time.
// ----------------------------------------------------------------------------
// Usage:
//   text  : valid/ready channel; command 0 carries one UTF-16 code unit in
//           char_code, command 1 ends the text (flush the open line, emit a
//           single file header line for empty text, then clear all state).
//   lines : valid/ready channel; one item per display line with its kind,
//           old and new line numbers and a continuation flag.
//   Throughput is one text item per cycle while the receiver is not stalling,
//   set by the state update between the input register and the line
//   register. The item that ends a line is held in the input register and
//   processed once the line register can take a result; the line item is
//   valid in the line register in the cycle after that item is processed.
//   Items that do not end a line (ordinary characters, the LF of a CRLF)
//   produce nothing.
//   When the receiver stalls, the held line stays in the line register and
//   one more text item may wait in the input register; text.ready falls
//   only when both are full.
//   rst is synchronous, active high: both registers empty, counters zero,
//   no hunk open, previous kind file header.
// ----------------------------------------------------------------------------
module unified_diff_line_scanner_top #(
  parameter int NUMBER_WIDTH = 31
) (
  input logic      clk,
  input logic      rst,
  udls_in_if.sink  text,
  udls_out_if.source lines
);
  import udls_pkg::*;

  // Input register.
  logic        in_valid;
  logic        in_command;
  logic [15:0] in_code;

  // Line register.
  logic                 out_valid;
  kind_t                out_kind;
  logic [OUT_NUM_W-1:0] out_old;
  logic [OUT_NUM_W-1:0] out_new;
  logic                 out_cont;

  // Scanner state.
  logic [NUMBER_WIDTH-1:0] old_counter, old_counter_next;
  logic [NUMBER_WIDTH-1:0] new_counter, new_counter_next;
  logic                    inside_hunk, inside_hunk_next;
  kind_t                   previous_kind, previous_kind_next;
  logic                    next_cont, next_cont_next;
  logic                    after_cr, after_cr_next;
  logic [1:0]              column, column_next;
  cls_t                    first_class, first_class_next;
  logic                    prefix_seen, prefix_seen_next;
  logic                    prev_at, prev_at_next;
  logic                    closed, closed_next;
  logic                    line_open, line_open_next;
  logic                    any_emitted, any_emitted_next;

  logic [NUMBER_WIDTH-1:0] minus_value, plus_value;
  logic                    minus_good, plus_good;
  numf_ctl_t               num_ctl;

  logic                    proc;
  logic                    is_term;
  logic                    do_emit, emit_cont, do_feed, do_reset;
  kind_t                   emit_kind;
  logic [NUMBER_WIDTH-1:0] emit_old, emit_new;

  // Process the held text item whenever the line register can take a result.
  assign proc       = in_valid && (!out_valid || lines.ready);
  assign text.ready = !in_valid || proc;

  assign is_term = (in_code == CH_LF) || (in_code == CH_CR) || (in_code == CH_PS)
                || (in_code == CH_NC0) || (in_code == CH_NC1);

  always_comb begin
    old_counter_next   = old_counter;
    new_counter_next   = new_counter;
    inside_hunk_next   = inside_hunk;
    previous_kind_next = previous_kind;
    next_cont_next     = next_cont;
    after_cr_next      = after_cr;
    column_next        = column;
    first_class_next   = first_class;
    prefix_seen_next   = prefix_seen;
    prev_at_next       = prev_at;
    closed_next        = closed;
    line_open_next     = line_open;
    any_emitted_next   = any_emitted;
    do_emit   = 1'b0;
    emit_cont = 1'b0;
    do_feed   = 1'b0;
    do_reset  = 1'b0;
    emit_kind = KIND_FILE_HEADER;
    emit_old  = '0;
    emit_new  = '0;
    num_ctl   = '0;

    // Route the item: end command, swallowed LF of a CRLF, terminator or text.
    if (proc) begin
      if (in_command) begin
        do_emit   = line_open || !any_emitted;
        emit_cont = line_open && next_cont;
        do_reset  = 1'b1;
      end else begin
        after_cr_next = 1'b0;
        if (after_cr && (in_code == CH_LF)) begin
          next_cont_next = 1'b0;
        end else if (is_term) begin
          do_emit        = 1'b1;
          emit_cont      = next_cont;
          next_cont_next = (in_code != CH_LF);
          after_cr_next  = (in_code == CH_CR);
        end else begin
          do_feed = 1'b1;
        end
      end
    end

    // Classify the finished line and advance the counters.
    if (do_emit) begin
      if (emit_cont) begin
        emit_kind = previous_kind;
      end else begin
        if (prefix_seen && closed && minus_good && plus_good) begin
          old_counter_next = minus_value;
          new_counter_next = plus_value;
          inside_hunk_next = 1'b1;
          emit_kind        = KIND_HUNK_HEADER;
        end else if (!inside_hunk) begin
          emit_kind = KIND_FILE_HEADER;
        end else begin
          case (first_class)
            CLS_EMPTY, CLS_SPACE: begin
              emit_kind = KIND_CONTEXT;
              emit_old  = old_counter;
              emit_new  = new_counter;
              if (old_counter != '1) old_counter_next = old_counter + 1'b1;
              if (new_counter != '1) new_counter_next = new_counter + 1'b1;
            end
            CLS_PLUS: begin
              emit_kind = KIND_ADDED;
              emit_new  = new_counter;
              if (new_counter != '1) new_counter_next = new_counter + 1'b1;
            end
            CLS_MINUS: begin
              emit_kind = KIND_REMOVED;
              emit_old  = old_counter;
              if (old_counter != '1) old_counter_next = old_counter + 1'b1;
            end
            CLS_BSLASH: begin
              emit_kind = KIND_NO_NEWLINE;
            end
            default: begin
              // Anything else ends the hunk.
              inside_hunk_next = 1'b0;
              emit_kind        = KIND_FILE_HEADER;
            end
          endcase
        end
        previous_kind_next = emit_kind;
      end
      any_emitted_next = 1'b1;
      column_next      = '0;
      first_class_next = CLS_EMPTY;
      prefix_seen_next = 1'b0;
      prev_at_next     = 1'b0;
      closed_next      = 1'b0;
      line_open_next   = 1'b0;
      num_ctl.clear    = 1'b1;
    end

    // Track the line prefix and the hunk header fields.
    if (do_feed) begin
      line_open_next = 1'b1;
      case (column)
        2'd0: begin
          case (in_code)
            CH_SPACE:  first_class_next = CLS_SPACE;
            CH_PLUS:   first_class_next = CLS_PLUS;
            CH_MINUS:  first_class_next = CLS_MINUS;
            CH_BSLASH: first_class_next = CLS_BSLASH;
            CH_AT:     first_class_next = CLS_AT;
            default:   first_class_next = CLS_OTHER;
          endcase
        end
        2'd1: begin
          prefix_seen_next = (first_class == CLS_AT) && (in_code == CH_AT);
        end
        default: begin
          if (prefix_seen && !closed) begin
            if ((in_code == CH_AT) && prev_at) begin
              closed_next = 1'b1;
            end else begin
              num_ctl.step = 1'b1;
            end
            prev_at_next = (in_code == CH_AT);
          end
        end
      endcase
      if (column != 2'd3) column_next = column + 2'd1;
    end

    // End of text: drop all state.
    if (do_reset) begin
      old_counter_next   = '0;
      new_counter_next   = '0;
      inside_hunk_next   = 1'b0;
      previous_kind_next = KIND_FILE_HEADER;
      next_cont_next     = 1'b0;
      after_cr_next      = 1'b0;
      column_next        = '0;
      first_class_next   = CLS_EMPTY;
      prefix_seen_next   = 1'b0;
      prev_at_next       = 1'b0;
      closed_next        = 1'b0;
      line_open_next     = 1'b0;
      any_emitted_next   = 1'b0;
      num_ctl.clear      = 1'b1;
    end
  end

  udls_num_field #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_minus (
    .clk    (clk),
    .rst    (rst),
    .ctl    (num_ctl),
    .code   (in_code),
    .marker (CH_MINUS),
    .value  (minus_value),
    .good   (minus_good)
  );

  udls_num_field #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_plus (
    .clk    (clk),
    .rst    (rst),
    .ctl    (num_ctl),
    .code   (in_code),
    .marker (CH_PLUS),
    .value  (plus_value),
    .good   (plus_good)
  );

  // Input register: load on accept, empty once processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text.ready) begin
      in_valid <= text.valid;
    end
    if (text.valid && text.ready) begin
      in_command <= text.command;
      in_code    <= text.char_code;
    end
  end

  // Line register and scanner state.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      old_counter   <= '0;
      new_counter   <= '0;
      inside_hunk   <= 1'b0;
      previous_kind <= KIND_FILE_HEADER;
      next_cont     <= 1'b0;
      after_cr      <= 1'b0;
      column        <= '0;
      first_class   <= CLS_EMPTY;
      prefix_seen   <= 1'b0;
      prev_at       <= 1'b0;
      closed        <= 1'b0;
      line_open     <= 1'b0;
      any_emitted   <= 1'b0;
    end else begin
      if (do_emit) begin
        out_valid <= 1'b1;
      end else if (lines.ready) begin
        out_valid <= 1'b0;
      end
      old_counter   <= old_counter_next;
      new_counter   <= new_counter_next;
      inside_hunk   <= inside_hunk_next;
      previous_kind <= previous_kind_next;
      next_cont     <= next_cont_next;
      after_cr      <= after_cr_next;
      column        <= column_next;
      first_class   <= first_class_next;
      prefix_seen   <= prefix_seen_next;
      prev_at       <= prev_at_next;
      closed        <= closed_next;
      line_open     <= line_open_next;
      any_emitted   <= any_emitted_next;
    end
    if (do_emit) begin
      out_kind <= emit_kind;
      out_old  <= OUT_NUM_W'({{OUT_NUM_W{1'b0}}, emit_old});
      out_new  <= OUT_NUM_W'({{OUT_NUM_W{1'b0}}, emit_new});
      out_cont <= emit_cont;
    end
  end

  assign lines.valid           = out_valid;
  assign lines.line_kind       = out_kind;
  assign lines.old_number      = out_old;
  assign lines.new_number      = out_new;
  assign lines.is_continuation = out_cont;

  // A continuation or header line never carries line numbers.
  a_cont_no_numbers: assert property (@(posedge clk) disable iff (rst)
    (lines.valid && lines.is_continuation) |-> (out_old == '0 && out_new == '0))
    else $error("continuation line carries line numbers");

  a_header_no_numbers: assert property (@(posedge clk) disable iff (rst)
    (lines.valid && !lines.is_continuation && lines.line_kind == KIND_HUNK_HEADER)
    |-> (out_old == '0 && out_new == '0))
    else $error("hunk header line carries line numbers");

  // End of text leaves the scanner in its reset state.
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (proc && in_command) |=> (!line_open && !inside_hunk && !any_emitted
                             && old_counter == '0 && new_counter == '0))
    else $error("state not cleared after end of text");

  // Back-pressure only when both registers hold an item.
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !text.ready |-> (in_valid && out_valid && !lines.ready))
    else $error("text stalled with room in the pipe");

endmodule

// ----- rtl/udls_num_field.sv -----
// ----------------------------------------------------------------------------
// udls_num_field
// One number field of a hunk header: finds its marker, then accumulates
// decimal digits and flags an overflow past the counter range.
// ----------------------------------------------------------------------------
module udls_num_field #(
  parameter int NUMBER_WIDTH = 31
) (
  input  logic                    clk,
  input  logic                    rst,
  input  udls_pkg::numf_ctl_t     ctl,
  input  logic [15:0]             code,
  input  logic [15:0]             marker,
  output logic [NUMBER_WIDTH-1:0] value,
  output logic                    good
);
  import udls_pkg::*;

  localparam int ACC_W = NUMBER_WIDTH + 4;

  phase_t                  phase;
  phase_t                  phase_next;
  logic [NUMBER_WIDTH-1:0] value_next;
  logic                    good_next;
  logic                    is_digit;
  logic [ACC_W-1:0]        acc;

  always_comb begin
    is_digit = code inside {[CH_ZERO:CH_NINE]};
    acc = ({4'b0, value} << 3) + ({4'b0, value} << 1)
        + {{NUMBER_WIDTH{1'b0}}, code[3:0]};
    phase_next = phase;
    value_next = value;
    good_next  = good;
    if (ctl.step) begin
      case (phase)
        PH_DIGITS: begin
          if (!is_digit) begin
            phase_next = PH_DONE;
          end else if (|acc[ACC_W-1:NUMBER_WIDTH]) begin
            good_next  = 1'b0;
            phase_next = PH_DONE;
          end else begin
            value_next = acc[NUMBER_WIDTH-1:0];
            good_next  = 1'b1;
          end
        end
        PH_IDLE: begin
          if (code == marker) begin
            phase_next = PH_DIGITS;
            value_next = '0;
            good_next  = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      phase <= PH_IDLE;
      value <= '0;
      good  <= 1'b0;
    end else begin
      phase <= phase_next;
      value <= value_next;
      good  <= good_next;
    end
  end

endmodule
